// ===== design/sitda_pkg.sv =====
package sitda_pkg;

    localparam int VALUE_W    = 32;
    localparam int CHAR_W     = 8;
    localparam int DIGIT_W    = 4;
    localparam int NUM_DIGITS = 10;
    localparam int BCD_W      = NUM_DIGITS * DIGIT_W;
    localparam int IDX_W      = 4;
    localparam int STEP_BITS  = 4;
    localparam int CONV_STEPS = VALUE_W / STEP_BITS;
    localparam int STEP_CNT_W = 3;

    localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'd45;
    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'd48;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CONV,
        ST_PREP,
        ST_SIGN,
        ST_DIGITS
    } state_t;

    typedef struct packed {
        logic load;
        logic step;
        logic prep;
        logic emit_sign;
        logic emit_digit;
    } ctrl_cmd_t;

    typedef struct packed {
        logic negative;
        logic conv_last;
        logic digit_last;
        logic out_free;
    } dp_status_t;

endpackage

// ===== design/sitda_ctrl.sv =====
module sitda_ctrl
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  sitda_pkg::dp_status_t status,
    output sitda_pkg::ctrl_cmd_t  cmd
);

    sitda_pkg::state_t state_reg;
    sitda_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= sitda_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            sitda_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = sitda_pkg::ST_CONV;
                end
            end
            sitda_pkg::ST_CONV:
            begin
                cmd.step = 1'b1;
                if (status.conv_last)
                begin
                    state_next = sitda_pkg::ST_PREP;
                end
            end
            sitda_pkg::ST_PREP:
            begin
                cmd.prep   = 1'b1;
                state_next = status.negative ? sitda_pkg::ST_SIGN : sitda_pkg::ST_DIGITS;
            end
            sitda_pkg::ST_SIGN:
            begin
                if (status.out_free)
                begin
                    cmd.emit_sign = 1'b1;
                    state_next    = sitda_pkg::ST_DIGITS;
                end
            end
            sitda_pkg::ST_DIGITS:
            begin
                if (status.out_free)
                begin
                    cmd.emit_digit = 1'b1;
                    if (status.digit_last)
                    begin
                        state_next = sitda_pkg::ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = sitda_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

// ===== design/sitda_datapath.sv =====
module sitda_datapath
(
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic signed [sitda_pkg::VALUE_W-1:0]   value,
    input  sitda_pkg::ctrl_cmd_t                   cmd,
    output sitda_pkg::dp_status_t                  status,
    output logic                                   out_valid,
    input  logic                                   out_ready,
    output logic [sitda_pkg::CHAR_W-1:0]           out_char,
    output logic                                   out_last
);

    logic [sitda_pkg::VALUE_W-1:0]    mag_reg;
    logic [sitda_pkg::VALUE_W-1:0]    mag_next;
    logic [sitda_pkg::BCD_W-1:0]      bcd_reg;
    logic [sitda_pkg::BCD_W-1:0]      bcd_next;
    logic                             neg_reg;
    logic [sitda_pkg::STEP_CNT_W-1:0] step_cnt_reg;
    logic [sitda_pkg::IDX_W-1:0]      idx_reg;
    logic [sitda_pkg::IDX_W-1:0]      top_idx;
    logic [sitda_pkg::DIGIT_W-1:0]    digit [sitda_pkg::NUM_DIGITS];
    logic                             out_valid_reg;
    logic [sitda_pkg::CHAR_W-1:0]     char_reg;
    logic                             last_reg;
    logic                             emit;

    // double dabble, four magnitude bits per cycle, msb first
    always_comb
    begin
        logic [sitda_pkg::BCD_W-1:0]   b;
        logic [sitda_pkg::VALUE_W-1:0] m;
        b = bcd_reg;
        m = mag_reg;
        for (int s = 0; s < sitda_pkg::STEP_BITS; s++)
        begin
            for (int d = 0; d < sitda_pkg::NUM_DIGITS; d++)
            begin
                if (b[d*sitda_pkg::DIGIT_W +: sitda_pkg::DIGIT_W] >= 4'd5)
                begin
                    b[d*sitda_pkg::DIGIT_W +: sitda_pkg::DIGIT_W] =
                        b[d*sitda_pkg::DIGIT_W +: sitda_pkg::DIGIT_W] + 4'd3;
                end
            end
            b = {b[sitda_pkg::BCD_W-2:0], m[sitda_pkg::VALUE_W-1]};
            m = {m[sitda_pkg::VALUE_W-2:0], 1'b0};
        end
        bcd_next = b;
        mag_next = m;
    end

    // most significant nonzero digit, zero gives digit 0
    always_comb
    begin
        top_idx = '0;
        for (int i = 0; i < sitda_pkg::NUM_DIGITS; i++)
        begin
            digit[i] = bcd_reg[i*sitda_pkg::DIGIT_W +: sitda_pkg::DIGIT_W];
            if (digit[i] != '0)
            begin
                top_idx = sitda_pkg::IDX_W'(i);
            end
        end
    end

    assign emit = cmd.emit_sign | cmd.emit_digit;

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            neg_reg <= value[sitda_pkg::VALUE_W-1];
            mag_reg <= value[sitda_pkg::VALUE_W-1] ? (~value + 1'b1) : value;
            bcd_reg <= '0;
        end
        else if (cmd.step)
        begin
            mag_reg <= mag_next;
            bcd_reg <= bcd_next;
        end

        if (cmd.prep)
        begin
            idx_reg <= top_idx;
        end
        else if (cmd.emit_digit)
        begin
            idx_reg <= idx_reg - 1'b1;
        end

        if (cmd.emit_sign)
        begin
            char_reg <= sitda_pkg::CHAR_MINUS;
            last_reg <= 1'b0;
        end
        else if (cmd.emit_digit)
        begin
            char_reg <= sitda_pkg::CHAR_ZERO + {4'd0, digit[idx_reg]};
            last_reg <= (idx_reg == '0);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_cnt_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.load)
            begin
                step_cnt_reg <= '0;
            end
            else if (cmd.step)
            begin
                step_cnt_reg <= step_cnt_reg + 1'b1;
            end

            if (emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign status.negative   = neg_reg;
    assign status.conv_last  =
        (step_cnt_reg == sitda_pkg::STEP_CNT_W'(sitda_pkg::CONV_STEPS - 1));
    assign status.digit_last = (idx_reg == '0);
    assign status.out_free   = !out_valid_reg || out_ready;

    assign out_valid = out_valid_reg;
    assign out_char  = char_reg;
    assign out_last  = last_reg;

endmodule

// ===== design/signed_int_to_decimal_ascii_top.sv =====
// signed 32-bit integer to decimal ascii text
//
// s_axis: one beat per integer, s_axis_tdata carries the two's complement value.
// m_axis: one beat per character, most significant first; a minus sign leads a
// negative value, digits have no leading zeros, zero gives a single '0'.
// m_axis_tlast marks the final character of each number (1 to 11 beats).
//
// timing: after the input beat the magnitude goes through a double-dabble
// binary to bcd converter at four bits per cycle, the prep state picks
// the leading digit, and one character is then loaded per cycle into the output
// register while the receiver keeps up; the next input beat can be taken in
// the cycle after the last character is loaded.
// s_axis_tready is high only while no number is in flight.
//
// reset clears the controller and the output valid; no beat is pending after it.
// when the receiver stalls, the output beat holds and character generation
// pauses until it is taken.
module signed_int_to_decimal_ascii_top
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    input  logic signed [sitda_pkg::VALUE_W-1:0] s_axis_tdata,  // [31:0] value
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    output logic [sitda_pkg::CHAR_W-1:0]         m_axis_tdata,  // [7:0] character
    output logic                                 m_axis_tlast
);

    sitda_pkg::ctrl_cmd_t  cmd;
    sitda_pkg::dp_status_t status;

    sitda_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .status   (status),
        .cmd      (cmd)
    );

    sitda_datapath u_datapath
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .value     (s_axis_tdata),
        .cmd       (cmd),
        .status    (status),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_char  (m_axis_tdata),
        .out_last  (m_axis_tlast)
    );

endmodule

// ===== design/sitda_checker.sv =====
module sitda_checker
(
    input logic                                 clk,
    input logic                                 rst_n,
    input logic                                 s_axis_tvalid,
    input logic                                 s_axis_tready,
    input logic                                 m_axis_tvalid,
    input logic                                 m_axis_tready,
    input logic [sitda_pkg::CHAR_W-1:0]         m_axis_tdata,
    input logic                                 m_axis_tlast
);

    // stalled output beat holds
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
        else $error("output beat changed while stalled");

    // only a minus sign or a decimal digit leaves the block
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |->
            (m_axis_tdata == sitda_pkg::CHAR_MINUS) ||
            ((m_axis_tdata >= sitda_pkg::CHAR_ZERO) && (m_axis_tdata <= 8'd57)))
        else $error("output character is not a sign or digit");

    // a minus sign is never the end of a number
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (m_axis_tdata == sitda_pkg::CHAR_MINUS) |-> !m_axis_tlast)
        else $error("minus sign marked last");

    // conversion plus leading digit pick keeps the input closed
    assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |-> ##10 !s_axis_tready)
        else $error("input reopened before conversion finished");

    assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready && !m_axis_tvalid ||
            !s_axis_tready && $past(m_axis_tvalid))
        else $error("input accepted twice in a row");

endmodule

bind signed_int_to_decimal_ascii_top sitda_checker u_sitda_checker (.*);

// ===== bench/tb_signed_int_to_decimal_ascii_top.sv =====
`timescale 1ns / 100ps

module tb_signed_int_to_decimal_ascii_top;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int HOLD_CYCLES  = 300;
    localparam int HOLD_AT_ITEM = 40;
    localparam int RANDOM_ITEMS = 100;
    localparam int MAX_REPORTS  = 10;

    typedef struct packed {
        logic [sitda_pkg::CHAR_W-1:0] ch;
        logic                         last;
    } char_beat_t;

    logic                                 clk = 1'b0;
    logic                                 rst_n = 1'b0;
    logic                                 s_axis_tvalid = 1'b0;
    logic                                 s_axis_tready;
    logic signed [sitda_pkg::VALUE_W-1:0] s_axis_tdata = '0;
    logic                                 m_axis_tvalid;
    logic                                 m_axis_tready = 1'b0;
    logic [sitda_pkg::CHAR_W-1:0]         m_axis_tdata;
    logic                                 m_axis_tlast;

    logic signed [sitda_pkg::VALUE_W-1:0] pending_values[$];
    char_beat_t                           expected_chars[$];
    int                                   mismatch_count = 0;
    int                                   ints_taken = 0;
    int                                   hold_left = 0;
    logic                                 hold_done = 1'b0;
    logic                                 quiet_run = 1'b0;
    int                                   cycle_count = 0;

    signed_int_to_decimal_ascii_top i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // decimal text of one integer, most significant character first
    task automatic push_decimal_text(input logic signed [sitda_pkg::VALUE_W-1:0] value);
        logic [sitda_pkg::VALUE_W-1:0] mag;
        logic [sitda_pkg::DIGIT_W-1:0] digit[sitda_pkg::NUM_DIGITS];
        int                            nd;
        char_beat_t                    beat;
        mag = value[sitda_pkg::VALUE_W-1] ? (32'd0 - value) : value;
        nd = 0;
        do
        begin
            digit[nd] = sitda_pkg::DIGIT_W'(mag % 10);
            mag = mag / 10;
            nd++;
        end while (mag != 0 && nd < sitda_pkg::NUM_DIGITS);
        if (value[sitda_pkg::VALUE_W-1])
        begin
            beat.ch = sitda_pkg::CHAR_MINUS;
            beat.last = 1'b0;
            expected_chars.push_back(beat);
        end
        while (nd > 0)
        begin
            nd--;
            beat.ch = sitda_pkg::CHAR_ZERO + digit[nd];
            beat.last = (nd == 0);
            expected_chars.push_back(beat);
        end
    endtask

    // random integer, weighted toward every text length and the edges
    function automatic logic signed [sitda_pkg::VALUE_W-1:0] draw_integer();
        longint lo;
        longint hi;
        longint mag;
        int     len;
        logic   neg;
        neg = 1'($urandom_range(0, 1));
        case ($urandom_range(0, 3))
            0: return $urandom();
            1:
            begin
                len = $urandom_range(1, 10);
                lo = (len == 1) ? 0 : 64'd10 ** (len - 1);
                hi = 64'd10 ** len - 1;
                if (hi > 64'd2147483648)
                    hi = 64'd2147483648;
                mag = lo + longint'($urandom()) % (hi - lo + 1);
            end
            2: mag = longint'($urandom_range(0, 99));
            default:
            begin
                len = $urandom_range(0, 9);
                mag = 64'd10 ** len + $urandom_range(0, 2) - 1;
                if ($urandom_range(0, 3) == 0)
                    mag = 64'd2147483648 - $urandom_range(0, 2);
            end
        endcase
        if (!neg && mag > 64'd2147483647)
            mag = 64'd2147483647;
        return sitda_pkg::VALUE_W'(neg ? -mag : mag);
    endfunction

    // sender: one integer per beat, random gap after each
    always @(posedge clk or negedge rst_n)
    begin
        int gap_left;
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata <= '0;
            gap_left = 0;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                push_decimal_text(s_axis_tdata);
                ints_taken <= ints_taken + 1;
            end
            if (!s_axis_tvalid || s_axis_tready)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    s_axis_tvalid <= 1'b0;
                end
                else if (pending_values.size() != 0)
                begin
                    s_axis_tdata <= pending_values.pop_front();
                    s_axis_tvalid <= 1'b1;
                    gap_left = quiet_run ? 0 : $urandom_range(0, 7);
                end
                else
                    s_axis_tvalid <= 1'b0;
            end
        end
    end

    // receiver: compare each character beat, random stall after each
    always @(posedge clk or negedge rst_n)
    begin
        int         stall_left;
        char_beat_t want;
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
            stall_left = 0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (expected_chars.size() == 0)
                begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS)
                        $display("unexpected character beat: char %0d last %0b",
                                 m_axis_tdata, m_axis_tlast);
                end
                else
                begin
                    want = expected_chars.pop_front();
                    if (m_axis_tdata !== want.ch || m_axis_tlast !== want.last)
                    begin
                        mismatch_count++;
                        if (mismatch_count <= MAX_REPORTS)
                            $display("character mismatch: expected %0d/%0b got %0d/%0b",
                                     want.ch, want.last, m_axis_tdata, m_axis_tlast);
                    end
                end
                stall_left = quiet_run ? 0 : $urandom_range(0, 7);
            end
            m_axis_tready <= (hold_left == 0) && (stall_left == 0);
            if (stall_left > 0)
                stall_left--;
        end
    end

    // one long receiver hold-off so the input side backs up
    always @(posedge clk)
    begin
        if (!hold_done && ints_taken == HOLD_AT_ITEM)
        begin
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end
        else if (hold_left > 0)
            hold_left <= hold_left - 1;
    end

    always @(posedge clk)
    begin
        if ($urandom_range(0, 63) == 0)
            quiet_run <= !quiet_run;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("signed_int_to_decimal_ascii_top regression: fail");
            $finish;
        end
    end

    initial
    begin
        pending_values.push_back(32'sd0);
        pending_values.push_back(32'sd1);
        pending_values.push_back(-32'sd1);
        pending_values.push_back(32'sd9);
        pending_values.push_back(32'sd10);
        pending_values.push_back(-32'sd10);
        pending_values.push_back(32'sd99);
        pending_values.push_back(32'sd100);
        pending_values.push_back(32'sd999999999);
        pending_values.push_back(32'sd1000000000);
        pending_values.push_back(-32'sd999999999);
        pending_values.push_back(-32'sd1000000000);
        pending_values.push_back(32'sd1234567890);
        pending_values.push_back(32'sd2147483647);
        pending_values.push_back(-32'sd2147483647);
        pending_values.push_back(32'h8000_0000);
        pending_values.push_back(32'h5555_5555);
        pending_values.push_back(32'hAAAA_AAAA);
        pending_values.push_back(32'h0000_FFFF);
        pending_values.push_back(32'hFFFF_0000);
        for (int i = 0; i < RANDOM_ITEMS; i++)
            pending_values.push_back(draw_integer());

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        while (pending_values.size() != 0 || s_axis_tvalid)
            @(posedge clk);
        while (expected_chars.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);

        if (mismatch_count == 0 && expected_chars.size() == 0)
            $display("signed_int_to_decimal_ascii_top regression: pass");
        else
            $display("signed_int_to_decimal_ascii_top regression: fail");
        $finish;
    end

endmodule
